// ===== sv/cba_pkg.sv =====
// shared types, codes and helpers for the contiguous block allocator
// no dependencies; used by cba_ctrl, cba_datapath and the top level
package cba_pkg;

  localparam int KEY_W      = 64;
  localparam int START_W    = 6;
  localparam int LEN_W      = 7;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 5;
  localparam int MAP_W      = 64;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 72;

  localparam logic OP_ALLOC  = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_BUSY     = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_ALLOC,
    SLOT_SCAN
  } slot_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load_req;
    logic      calc_mask;
    logic      alloc_commit;
    logic      scan_start;
    logic      scan_read;
    logic      scan_next;
    logic      free_commit;
    logic      res_load;
    status_t   res_status;
    slot_sel_t res_slot_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_bad;
    logic busy;
    logic full;
    logic scan_end;
    logic hit;
    logic out_busy;
  } stat_t;

  // bit i set when first <= i < first + len
  function automatic logic [MAP_W-1:0] run_mask(input logic [START_W-1:0] first,
                                                input logic [LEN_W-1:0] len);
    logic [MAP_W-1:0] m;
    logic [7:0]       run_end;
    run_end = 8'(first) + 8'(len);
    for (int i = 0; i < MAP_W; i++) begin
      m[i] = (8'(i) >= 8'(first)) && (8'(i) < run_end);
    end
    return m;
  endfunction

endpackage

// ===== sv/contiguous_block_allocator.sv =====
// top level of the contiguous block allocator: stream ports, sequencer and datapath
// depends on cba_pkg, cba_ctrl and cba_datapath
//
// Keeps a bit map of BLOCKS storage blocks and a directory of ENTRIES file slots.
// An allocate word claims block_count blocks from start_block and appends an
// entry in the next unused slot (slots are never reused); it is turned away as
// out of range (zero length or run past the last block), busy (any block of the
// run already taken) or directory full, in that order, and a turned-away request
// changes nothing. A delete word frees the run of the lowest live slot whose key
// matches and retires the slot, or reports not found. Every request word gives
// exactly one result word with the status, the slot and the map after the
// request. One request is worked at a time. An allocate goes from acceptance
// to result through accept, run mask, then decide and write back. A delete
// walks the directory memory through its single registered read port, reading
// and then comparing one entry at a time from slot 0; a miss ends once all used
// slots are read, used being the number of slots handed out so far. The
// result sits in an output register, so the next request is taken while the
// last result still waits; a result that cannot be written stalls the sequencer.
// Reset is synchronous and needs no clearing pass.
module contiguous_block_allocator #(
  parameter int BLOCKS  = 64,
  parameter int ENTRIES = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cba_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // name_key, start_block, block_count
  input  logic                              s_axis_tuser,  // opcode
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cba_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // status, slot, block_map
);
  import cba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [KEY_W-1:0]    in_key;
  logic [START_W-1:0]  in_start;
  logic [LEN_W-1:0]    in_len;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [MAP_W-1:0]    res_map;

  // unpack the request word, lowest field first
  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_start = s_axis_tdata[KEY_W +: START_W];
  assign in_len   = s_axis_tdata[KEY_W + START_W +: LEN_W];

  // result word: status in the low bits, then slot, then the full map
  assign m_axis_tdata = {res_map, res_slot, res_status};

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_op    (s_axis_tuser),
    .req_ready (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cba_datapath #(
    .BLOCKS  (BLOCKS),
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (in_key),
    .in_start   (in_start),
    .in_len     (in_len),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res_status (res_status),
    .res_slot   (res_slot),
    .res_map    (res_map)
  );

endmodule

// ===== sv/cba_ctrl.sv =====
// request sequencer: allocate check/commit and directory scan for delete
// depends on cba_pkg for command and status structs
module cba_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_op,
  output logic            req_ready,
  input  cba_pkg::stat_t  stat,
  output cba_pkg::cmd_t   cmd
);
  import cba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MASK,
    S_DECIDE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_FREE
  } state_t;

  state_t state, state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (req_op == OP_DELETE) begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN_RD;
          end else begin
            state_next = S_MASK;
          end
        end
      end
      S_MASK: begin
        cmd.calc_mask = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
          priority if (stat.range_bad) begin
            cmd.res_status = ST_RANGE;
          end else if (stat.busy) begin
            cmd.res_status = ST_BUSY;
          end else if (stat.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.res_status   = ST_OK;
            cmd.res_slot_sel = SLOT_ALLOC;
            cmd.alloc_commit = 1'b1;
          end
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          if (!stat.out_busy) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_NOTFOUND;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.scan_read = 1'b1;
          state_next    = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.hit) begin
          state_next = S_FREE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_FREE: begin
        if (!stat.out_busy) begin
          cmd.free_commit  = 1'b1;
          cmd.res_load     = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_slot_sel = SLOT_SCAN;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/cba_datapath.sv =====
// occupancy map, directory memory, live bits, slot counter and result register
// depends on cba_pkg for widths, codes, structs and run_mask
module cba_datapath #(
  parameter int BLOCKS  = 64,
  parameter int ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cba_pkg::cmd_t                 cmd,
  output cba_pkg::stat_t                stat,
  input  logic [cba_pkg::KEY_W-1:0]     in_key,
  input  logic [cba_pkg::START_W-1:0]   in_start,
  input  logic [cba_pkg::LEN_W-1:0]     in_len,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [cba_pkg::STATUS_W-1:0]  res_status,
  output logic [cba_pkg::SLOT_W-1:0]    res_slot,
  output logic [cba_pkg::MAP_W-1:0]     res_map
);
  import cba_pkg::*;

  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = KEY_W + START_W + LEN_W;

  // request registers
  logic [KEY_W-1:0]   key_q;
  logic [START_W-1:0] start_q;
  logic [LEN_W-1:0]   len_q;

  logic [BLOCKS-1:0]  occ_map;
  logic [BLOCKS-1:0]  occ_map_next;
  logic [BLOCKS-1:0]  mask_q;
  logic               range_bad_q;
  logic [ENTRIES-1:0] live;
  logic [CNT_W-1:0]   used_cnt;
  logic [CNT_W-1:0]   scan_idx;

  logic [ENTRY_W-1:0] entry_mem [ENTRIES];
  logic [ENTRY_W-1:0] rd_entry;
  logic [KEY_W-1:0]   rd_key;
  logic [START_W-1:0] rd_start;
  logic [LEN_W-1:0]   rd_len;
  logic [BLOCKS-1:0]  free_mask;
  logic [7:0]         run_end;
  logic [SLOT_W-1:0]  slot_pick;

  assign rd_key    = rd_entry[ENTRY_W-1 -: KEY_W];
  assign rd_start  = rd_entry[LEN_W +: START_W];
  assign rd_len    = rd_entry[LEN_W-1:0];
  assign free_mask = BLOCKS'(run_mask(rd_start, rd_len));
  assign run_end   = 8'(start_q) + 8'(len_q);

  assign stat.range_bad = range_bad_q;
  assign stat.busy      = |(occ_map & mask_q);
  assign stat.full      = (used_cnt == CNT_W'(ENTRIES));
  assign stat.scan_end  = (scan_idx >= used_cnt);
  assign stat.hit       = live[scan_idx[IDX_W-1:0]] && (rd_key == key_q);
  assign stat.out_busy  = res_valid && !res_ready;

  always_comb begin
    occ_map_next = occ_map;
    if (cmd.alloc_commit) begin
      occ_map_next = occ_map | mask_q;
    end else if (cmd.free_commit) begin
      occ_map_next = occ_map & ~free_mask;
    end
  end

  always_comb begin
    unique case (cmd.res_slot_sel)
      SLOT_ALLOC: slot_pick = SLOT_W'(used_cnt[IDX_W-1:0]);
      SLOT_SCAN:  slot_pick = SLOT_W'(scan_idx[IDX_W-1:0]);
      default:    slot_pick = '0;
    endcase
  end

  // request, mask and result registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      key_q   <= in_key;
      start_q <= in_start;
      len_q   <= in_len;
    end
    if (cmd.calc_mask) begin
      mask_q      <= BLOCKS'(run_mask(start_q, len_q));
      range_bad_q <= (len_q == '0) || (run_end > 8'(BLOCKS));
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_slot   <= slot_pick;
      res_map    <= MAP_W'(occ_map_next);
    end
  end

  // directory memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      entry_mem[used_cnt[IDX_W-1:0]] <= {key_q, start_q, len_q};
    end
    if (cmd.scan_read) begin
      rd_entry <= entry_mem[scan_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ_map   <= '0;
      live      <= '0;
      used_cnt  <= '0;
      scan_idx  <= '0;
      res_valid <= 1'b0;
    end else begin
      occ_map <= occ_map_next;
      if (cmd.alloc_commit) begin
        live[used_cnt[IDX_W-1:0]] <= 1'b1;
        used_cnt                  <= used_cnt + 1'b1;
      end
      if (cmd.free_commit) begin
        live[scan_idx[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (cmd.scan_next) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
